### hw/rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants
// Operator codes, rank tables, word types, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int OP_DEPTH  = 16;
  localparam int VAL_DEPTH = 16;
  localparam int FRAC_BITS = 32;
  localparam int OP_IDX_W  = $clog2(OP_DEPTH);
  localparam int OP_CNT_W  = OP_IDX_W + 1;
  localparam int VAL_IDX_W = $clog2(VAL_DEPTH);
  localparam int VAL_CNT_W = VAL_IDX_W + 1;
  localparam int STEP_W    = 8;
  localparam logic [STEP_W-1:0] MUL_STEPS = 8'd4;
  localparam logic [STEP_W-1:0] DIV_STEPS = 8'd128;

  typedef enum logic [2:0] {
    OP_HASH, OP_OPEN, OP_CLOSE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM
  } op_code_t;

  typedef enum logic [1:0] {EX_MUL, EX_DIV, EX_REM} ex_kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHAR, S_CMP, S_RED, S_RED2, S_EXST, S_EXWAIT, S_TAIL, S_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               missing_operand;
    logic               divide_by_zero;
    logic               stack_overflow;
    logic               no_result;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic load_char;
    logic push_char;
    logic use_close;
    logic push_op;
    logic pop_op;
    logic set_miss;
    logic pop_right;
    logic pop_left;
    logic exec_start;
    logic push_result;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_operand;
    logic last;
    logic closing;
    logic rank_lt;
    logic rank_eq;
    logic red_noop;
    logic val_empty;
    logic exec_done;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [2:0] in_rank(op_code_t op);
    logic [2:0] r;
    unique case (op)
      OP_HASH:  r = 3'd0;
      OP_OPEN:  r = 3'd1;
      OP_CLOSE: r = 3'd6;
      OP_ADD, OP_SUB: r = 3'd3;
      default:  r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] arr_rank(op_code_t op);
    logic [2:0] r;
    unique case (op)
      OP_HASH:  r = 3'd0;
      OP_OPEN:  r = 3'd6;
      OP_CLOSE: r = 3'd1;
      OP_ADD, OP_SUB: r = 3'd2;
      default:  r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic op_code_t char_code(logic [7:0] ch);
    op_code_t c;
    unique case (ch)
      8'h28:   c = OP_OPEN;
      8'h29:   c = OP_CLOSE;
      8'h2B:   c = OP_ADD;
      8'h2D:   c = OP_SUB;
      8'h2A:   c = OP_MUL;
      8'h2F:   c = OP_DIV;
      8'h25:   c = OP_REM;
      default: c = OP_HASH;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/iee_ctrl.sv
// ----------------------------------------------------------------------------
// iee_ctrl: evaluation sequencer
// Walks each character through compare, reduce and push steps.
// ----------------------------------------------------------------------------
module iee_ctrl
  import iee_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CHAR;
      S_CHAR:   state_nxt = stat.is_operand ? S_TAIL : S_CMP;
      S_CMP: begin
        if (stat.rank_lt || stat.rank_eq) state_nxt = S_TAIL;
        else                              state_nxt = S_RED;
      end
      S_RED:    state_nxt = (stat.red_noop || stat.val_empty) ? S_CMP : S_RED2;
      S_RED2:   state_nxt = stat.val_empty ? S_CMP : S_EXST;
      S_EXST:   state_nxt = S_EXWAIT;
      S_EXWAIT: if (stat.exec_done) state_nxt = S_CMP;
      S_TAIL: begin
        if (!stat.last)        state_nxt = S_IDLE;
        else if (stat.closing) state_nxt = S_OUT;
        else                   state_nxt = S_CMP;
      end
      S_OUT:    if (!stat.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_char = in_valid;
      end
      S_CHAR:   cmd.push_char = stat.is_operand;
      S_CMP: begin
        cmd.push_op = stat.rank_lt;
        cmd.pop_op  = !stat.rank_lt;
      end
      S_RED: begin
        cmd.set_miss  = !stat.red_noop && stat.val_empty;
        cmd.pop_right = !stat.red_noop && !stat.val_empty;
      end
      S_RED2: begin
        cmd.set_miss = stat.val_empty;
        cmd.pop_left = !stat.val_empty;
      end
      S_EXST:   cmd.exec_start  = 1'b1;
      S_EXWAIT: cmd.push_result = stat.exec_done;
      S_TAIL:   cmd.use_close   = stat.last && !stat.closing;
      S_OUT:    cmd.load_out    = !stat.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

### hw/rtl/iee_dp.sv
// ----------------------------------------------------------------------------
// iee_dp: stacks, arithmetic and output register
// Operator and value stacks, sequential multiply/divide unit, error flags.
// ----------------------------------------------------------------------------
module iee_dp
  import iee_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QMIN = 64'sh8000_0000_0000_0000;

  op_code_t           ops_r [OP_DEPTH];
  logic signed [63:0] vals_r [VAL_DEPTH];
  logic [OP_CNT_W-1:0]  op_cnt_r;
  logic [VAL_CNT_W-1:0] val_cnt_r;
  logic       started_r, closing_r, last_r;
  op_code_t   code_r, red_op_r;
  logic [7:0] ch_r;
  logic       miss_r, div0_r, ovf_r, sat_r;
  logic signed [63:0] left_r, right_r, res_r;
  logic [127:0] acc_r, num_r, quo_r;
  logic [63:0]  ma_r, mb_r, rem_r;
  logic         neg_r, lneg_r, busy_r, done_r;
  ex_kind_t     kind_r;
  logic [STEP_W-1:0] step_r;
  out_word_t    out_r;
  logic         out_valid_r;

  op_code_t           top_op;
  logic [OP_IDX_W-1:0]  op_top_idx;
  logic [VAL_IDX_W-1:0] val_top_idx;
  logic signed [63:0] val_top, char_val, add_res, push_data;
  logic               add_ovf, push_en, push_sat;
  logic [8:0]         ch_diff;
  logic [63:0]        mag_l, mag_r;
  logic [31:0]        mul_x, mul_y;
  logic [63:0]        pp;
  logic [127:0]       pp_sh, acc_sh;
  logic [64:0]        rem_sh;
  logic               rem_ge;

  function automatic logic [64:0] clamp(logic neg, logic [63:0] hi, logic [63:0] lo);
    logic [64:0] r;
    if (neg) begin
      if (hi != '0 || lo > 64'h8000_0000_0000_0000) r = {1'b1, QMIN};
      else r = {1'b0, 64'(-lo)};
    end else begin
      if (hi != '0 || lo[63]) r = {1'b1, QMAX};
      else r = {1'b0, lo};
    end
    return r;
  endfunction

  assign op_top_idx  = OP_IDX_W'(op_cnt_r - 1'b1);
  assign val_top_idx = VAL_IDX_W'(val_cnt_r - 1'b1);
  assign top_op      = (op_cnt_r != '0) ? ops_r[op_top_idx] : OP_HASH;
  assign val_top     = vals_r[val_top_idx];

  assign ch_diff  = {1'b0, ch_r} - 9'd48;
  assign char_val = {{(64 - 9){ch_diff[8]}}, ch_diff} << FRAC_BITS;

  assign mag_l = left_r[63]  ? 64'(-left_r)  : left_r;
  assign mag_r = right_r[63] ? 64'(-right_r) : right_r;

  always_comb begin
    logic sa, sb;
    add_res = (red_op_r == OP_SUB) ? left_r - right_r : left_r + right_r;
    sa      = left_r[63];
    sb      = (red_op_r == OP_SUB) ? ~right_r[63] : right_r[63];
    add_ovf = (sa == sb) && (add_res[63] != sa);
  end

  assign mul_x  = step_r[0] ? ma_r[63:32] : ma_r[31:0];
  assign mul_y  = step_r[1] ? mb_r[63:32] : mb_r[31:0];
  assign pp     = mul_x * mul_y;
  assign pp_sh  = {64'b0, pp} << {{1'b0, step_r[0]} + {1'b0, step_r[1]}, 5'b0};
  assign acc_sh = acc_r >> FRAC_BITS;

  assign rem_sh = {rem_r, num_r[127]};
  assign rem_ge = rem_sh >= {1'b0, mb_r};

  assign push_en   = cmd.push_char || cmd.push_result;
  assign push_data = cmd.push_char ? char_val : res_r;
  assign push_sat  = 1'b0;

  always_ff @(posedge clk) begin
    logic [64:0] cl;
    logic        dn;
    cl = '0;
    dn = 1'b0;
    if (!rst_n) begin
      op_cnt_r    <= '0;
      val_cnt_r   <= '0;
      started_r   <= 1'b0;
      closing_r   <= 1'b0;
      miss_r      <= 1'b0;
      div0_r      <= 1'b0;
      ovf_r       <= 1'b0;
      sat_r       <= 1'b0;
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_char) begin
        ch_r      <= in_data.ch;
        last_r    <= in_data.last;
        code_r    <= char_code(in_data.ch);
        closing_r <= 1'b0;
      end
      if (cmd.use_close) begin
        code_r    <= OP_CLOSE;
        closing_r <= 1'b1;
      end
      if (cmd.pop_op) begin
        red_op_r <= top_op;
        if (op_cnt_r != '0) op_cnt_r <= op_cnt_r - 1'b1;
      end
      if (cmd.push_op) begin
        if (op_cnt_r >= OP_CNT_W'(OP_DEPTH)) ovf_r <= 1'b1;
        else begin
          ops_r[OP_IDX_W'(op_cnt_r)] <= code_r;
          op_cnt_r <= op_cnt_r + 1'b1;
        end
      end
      if (cmd.set_miss) miss_r <= 1'b1;
      if (cmd.pop_right) begin
        right_r   <= val_top;
        val_cnt_r <= val_cnt_r - 1'b1;
      end
      if (cmd.pop_left) begin
        left_r    <= val_top;
        val_cnt_r <= val_cnt_r - 1'b1;
      end
      if (push_en) begin
        if (val_cnt_r >= VAL_CNT_W'(VAL_DEPTH)) ovf_r <= 1'b1;
        else begin
          vals_r[VAL_IDX_W'(val_cnt_r)] <= push_data;
          val_cnt_r <= val_cnt_r + 1'b1;
        end
      end
      if (push_sat) sat_r <= 1'b1;
      if (cmd.exec_start) begin
        neg_r  <= left_r[63] ^ right_r[63];
        lneg_r <= left_r[63];
        step_r <= '0;
        acc_r  <= '0;
        rem_r  <= '0;
        quo_r  <= '0;
        ma_r   <= mag_l;
        mb_r   <= mag_r;
        priority if (red_op_r == OP_ADD || red_op_r == OP_SUB) begin
          res_r  <= add_ovf ? (left_r[63] ? QMIN : QMAX) : add_res;
          if (add_ovf) sat_r <= 1'b1;
          dn = 1'b1;
        end else if (red_op_r == OP_MUL) begin
          kind_r <= EX_MUL;
          busy_r <= 1'b1;
        end else if (right_r == '0) begin
          div0_r <= 1'b1;
          res_r  <= left_r[63] ? QMIN : QMAX;
          dn = 1'b1;
        end else begin
          kind_r <= (red_op_r == OP_DIV) ? EX_DIV : EX_REM;
          num_r  <= (red_op_r == OP_DIV) ? ({64'b0, mag_l} << FRAC_BITS) : {64'b0, mag_l};
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (kind_r == EX_MUL) begin
          if (step_r == MUL_STEPS) begin
            cl     = clamp(neg_r, acc_sh[127:64], acc_sh[63:0]);
            res_r  <= cl[63:0];
            if (cl[64]) sat_r <= 1'b1;
            busy_r <= 1'b0;
            dn = 1'b1;
          end else begin
            acc_r <= acc_r + pp_sh;
          end
        end else if (step_r == DIV_STEPS) begin
          busy_r <= 1'b0;
          dn = 1'b1;
          if (kind_r == EX_DIV) begin
            cl    = clamp(neg_r, quo_r[127:64], quo_r[63:0]);
            res_r <= cl[63:0];
            if (cl[64]) sat_r <= 1'b1;
          end else begin
            res_r <= lneg_r ? 64'(-rem_r) : rem_r;
          end
        end else begin
          num_r <= num_r << 1;
          rem_r <= rem_ge ? 64'(rem_sh - {1'b0, mb_r}) : rem_sh[63:0];
          quo_r <= {quo_r[126:0], rem_ge};
        end
      end
      done_r <= dn;
      if (cmd.load_out) begin
        out_r.result_value    <= (val_cnt_r == '0) ? '0 : val_top;
        out_r.no_result       <= (val_cnt_r == '0);
        out_r.missing_operand <= miss_r;
        out_r.divide_by_zero  <= div0_r;
        out_r.stack_overflow  <= ovf_r;
        out_r.saturated       <= sat_r;
      end
      if (cmd.load_char && !started_r) begin
        op_cnt_r  <= OP_CNT_W'(2);
        ops_r[0]  <= OP_HASH;
        ops_r[1]  <= OP_OPEN;
        val_cnt_r <= '0;
        miss_r    <= 1'b0;
        div0_r    <= 1'b0;
        ovf_r     <= 1'b0;
        sat_r     <= 1'b0;
      end
      if (cmd.load_char) started_r <= 1'b1;
      if (cmd.load_out) begin
        started_r   <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.is_operand = (code_r == OP_HASH);
    stat.last       = last_r;
    stat.closing    = closing_r;
    stat.rank_lt    = in_rank(top_op) < arr_rank(code_r);
    stat.rank_eq    = in_rank(top_op) == arr_rank(code_r);
    stat.red_noop   = (red_op_r == OP_HASH) || (red_op_r == OP_OPEN) ||
                      (red_op_r == OP_CLOSE);
    stat.val_empty  = (val_cnt_r == '0);
    stat.exec_done  = done_r;
    stat.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/infix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top: two-stack infix evaluator
// Input words carry one expression character and a last flag; the word with
// last set produces one output word: the Q32.32 value on top of the value
// stack plus sticky error flags for the expression.
// Channels: in_valid/in_ready/in_data and out_valid/out_ready/out_data.
// An operand character passes through the char and tail states before in_ready
// returns. An operator passes through char, compare and tail, plus one
// reduction (pop right, pop left, execute, wait) per stacked operator it pops;
// + and - finish in the execute state; *, / and % wait on the sequential
// unit, whose divider retires one quotient bit per cycle. The last word adds
// the closing reduction chain and the output register load before out_valid.
// One character is worked on at a time; the controller sequence sets rate.
// Reset clears both stacks, the error flags and the output valid flag.
// A stalled receiver holds the result in the output register; the block keeps
// accepting words of the next expression and only waits when a new result
// is ready while the previous one is still held.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top
  import iee_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iee_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/sv/infix_expression_evaluator_top_tb.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top_tb: self-checking testbench
// Drives expression characters, predicts each result word with a two-stack
// evaluator model in Q32.32, and checks results in order under random stalls.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top_tb;
  import iee_pkg::*;

  localparam int MAX_IDLE_CYCLES = 20000;
  localparam int N_ROWS = 16;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  infix_expression_evaluator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // evaluator state
  op_code_t          ops[OP_DEPTH];
  int                op_cnt;
  logic signed [63:0] vals[VAL_DEPTH];
  int                val_cnt;
  bit                started;
  bit                f_miss, f_div0, f_ovf, f_sat;

  out_word_t expected_words[$];
  out_word_t last_word;
  int        mismatches;
  int        in_idle_pct, out_idle_pct;
  int        idle_cycles;
  bit        timed_out;

  string     row_expr[N_ROWS];
  bit        row_typed[N_ROWS];
  out_word_t row_want[N_ROWS];

  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic [2:0] stack_rank(op_code_t c);
    case (c)
      OP_HASH: return 3'd0;
      OP_OPEN: return 3'd1;
      OP_CLOSE: return 3'd6;
      OP_ADD, OP_SUB: return 3'd3;
      default: return 3'd5;
    endcase
  endfunction

  function automatic logic [2:0] incoming_rank(op_code_t c);
    case (c)
      OP_OPEN: return 3'd6;
      OP_CLOSE: return 3'd1;
      OP_ADD, OP_SUB: return 3'd2;
      OP_HASH: return 3'd0;
      default: return 3'd4;
    endcase
  endfunction

  function automatic op_code_t code_of(logic [7:0] ch);
    case (ch)
      "(": return OP_OPEN;
      ")": return OP_CLOSE;
      "+": return OP_ADD;
      "-": return OP_SUB;
      "*": return OP_MUL;
      "/": return OP_DIV;
      "%": return OP_REM;
      default: return OP_HASH;
    endcase
  endfunction

  function automatic logic signed [63:0] clamp_mag(bit neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) begin
        f_sat = 1;
        return Q_MIN;
      end
      return -$signed(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin
      f_sat = 1;
      return Q_MAX;
    end
    return $signed(m[63:0]);
  endfunction

  function automatic void push_val(logic signed [63:0] v);
    if (val_cnt >= VAL_DEPTH) f_ovf = 1;
    else begin
      vals[val_cnt] = v;
      val_cnt++;
    end
  endfunction

  function automatic void push_op(op_code_t c);
    if (op_cnt >= OP_DEPTH) f_ovf = 1;
    else begin
      ops[op_cnt] = c;
      op_cnt++;
    end
  endfunction

  function automatic void apply_op(op_code_t c);
    logic signed [63:0] l, r, res;
    logic signed [64:0] s;
    logic [63:0] ml, mr;
    logic [127:0] m;
    bit neg;
    if (c inside {OP_HASH, OP_OPEN, OP_CLOSE}) return;
    if (val_cnt == 0) begin
      f_miss = 1;
      return;
    end
    val_cnt--;
    r = vals[val_cnt];
    if (val_cnt == 0) begin
      f_miss = 1;
      return;
    end
    val_cnt--;
    l = vals[val_cnt];
    ml = l[63] ? -l : l;
    mr = r[63] ? -r : r;
    neg = l[63] ^ r[63];
    case (c)
      OP_ADD, OP_SUB: begin
        s = (c == OP_ADD) ? {l[63], l} + {r[63], r} : {l[63], l} - {r[63], r};
        if (s[64] != s[63]) begin
          f_sat = 1;
          res = s[64] ? Q_MIN : Q_MAX;
        end else res = s[63:0];
      end
      OP_MUL: begin
        m = {64'd0, ml} * {64'd0, mr};
        res = clamp_mag(neg, m >> FRAC_BITS);
      end
      default: begin
        if (r == 0) begin
          f_div0 = 1;
          res = l[63] ? Q_MIN : Q_MAX;
        end else if (c == OP_DIV) begin
          m = ({64'd0, ml} << FRAC_BITS) / {64'd0, mr};
          res = clamp_mag(neg, m);
        end else begin
          ml = ml % mr;
          res = l[63] ? -$signed(ml) : $signed(ml);
        end
      end
    endcase
    push_val(res);
  endfunction

  function automatic void take_op(op_code_t c);
    op_code_t top;
    forever begin
      top = op_cnt ? ops[op_cnt-1] : OP_HASH;
      if (stack_rank(top) < incoming_rank(c)) begin
        push_op(c);
        return;
      end
      if (op_cnt) op_cnt--;
      if (stack_rank(top) == incoming_rank(c)) return;
      apply_op(top);
    end
  endfunction

  function automatic bit evaluate_char(in_word_t w, output out_word_t o);
    op_code_t c;
    logic signed [63:0] v;
    if (!started) begin
      op_cnt = 0; val_cnt = 0;
      {f_miss, f_div0, f_ovf, f_sat} = '0;
      push_op(OP_HASH);
      push_op(OP_OPEN);
      started = 1;
    end
    c = code_of(w.ch);
    if (c == OP_HASH) begin
      v = $signed({56'd0, w.ch}) - 64'sd48;
      push_val(v <<< FRAC_BITS);
    end else take_op(c);
    if (!w.last) return 0;
    take_op(OP_CLOSE);
    o.no_result       = (val_cnt == 0);
    o.result_value    = val_cnt ? vals[val_cnt-1] : '0;
    o.missing_operand = f_miss;
    o.divide_by_zero  = f_div0;
    o.stack_overflow  = f_ovf;
    o.saturated       = f_sat;
    started = 0;
    return 1;
  endfunction

  task automatic send_word(logic [7:0] ch, bit last);
    out_word_t o;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < in_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{ch: ch, last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (evaluate_char('{ch: ch, last: last}, o)) begin
      expected_words.push_back(o);
      last_word = o;
    end
    @(negedge clk);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic send_checked(string s, out_word_t want);
    send_string(s);
    if (last_word !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row %s: typed %h predicted %h", s, want, last_word);
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_data);
        end else begin
          e = expected_words.pop_front();
          if (out_data.result_value !== e.result_value ||
              out_data.missing_operand !== e.missing_operand ||
              out_data.divide_by_zero !== e.divide_by_zero ||
              out_data.stack_overflow !== e.stack_overflow ||
              out_data.no_result !== e.no_result ||
              out_data.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected %h actual %h", e, out_data);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk)
    if (idle_cycles >= MAX_IDLE_CYCLES && !timed_out) begin
      timed_out = 1;
      $display("infix_expression_evaluator_top verification failed");
      $finish;
    end

  function automatic string random_expr();
    string s, ops_str;
    int n;
    ops_str = "+-*/%";
    s = "";
    n = $urandom_range(1, 5);
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(255)))};
      return s;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(5) == 0) s = {s, "("};
      s = {s, string'(byte'($urandom_range(3) == 0 ? $urandom_range(255)
                                                   : $urandom_range(48, 57)))};
      if ($urandom_range(5) == 0) s = {s, ")"};
      if (i != n - 1) s = {s, string'(ops_str[$urandom_range(4)])};
    end
    return s;
  endfunction

  initial begin
    string s;
    int sent;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 0;
    started = 0;
    op_cnt = 0;
    val_cnt = 0;
    last_word = '0;
    {f_miss, f_div0, f_ovf, f_sat} = '0;
    in_idle_pct = 11;
    out_idle_pct = 67;

    row_expr = '{"7", "+", "8/0", "0-8/0", ")", "3+4*2", "(9-2)%4", "7/2*3",
                 "((((((((((((((((1", "12345678901234567",
                 "\377*\377*\377*\377", "0-\377*\377*\377*\377",
                 "9/7", "0-9%4", "5*)", "2*(3+4))"};
    foreach (row_typed[i]) begin
      row_typed[i] = 1'b0;
      row_want[i]  = '0;
    end
    row_typed[0] = 1'b1;
    row_want[0]  = '{64'sh7_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    row_typed[1] = 1'b1;
    row_want[1]  = '{64'sd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    row_typed[2] = 1'b1;
    row_want[2]  = '{Q_MAX, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    row_typed[3] = 1'b1;
    row_want[3]  = '{-Q_MAX, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    row_typed[4] = 1'b1;
    row_want[4]  = '{64'sd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (row_expr[i]) begin
      if (row_typed[i]) send_checked(row_expr[i], row_want[i]);
      else send_string(row_expr[i]);
    end
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    @(negedge clk);

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 11 : (phase == 1) ? 67 : 0;
      out_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 11 : 0;
      while (sent < 400 * (phase + 1)) begin
        s = random_expr();
        send_string(s);
        sent += s.len();
      end
      in_valid <= 1'b0;
      wait (expected_words.size() == 0);
      @(negedge clk);
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("infix_expression_evaluator_top verification clean");
    else
      $display("infix_expression_evaluator_top verification failed");
    $finish;
  end

endmodule
